// ----- hw/rtl/matrix3_inverse_assert.svh -----
// Assertion macros shared by the matrix3_inverse checker.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define MI3_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matrix3_inverse check failed");

// Next-cycle implication, live through reset.
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("matrix3_inverse check failed");

`endif

// ----- hw/rtl/mi3_pkg.sv -----
// Types and constants shared by the matrix3_inverse modules.
package mi3_pkg;

    localparam int N_ELEM  = 9;
    localparam int COF_W   = 64;   // exact 2x2 cross product
    localparam int DET_W   = 98;   // exact determinant, signed
    localparam int QI_BITS = 33;   // integer quotient bits before saturation

    // Element indexes (row*3+col) of the cofactor cross products: A*B - C*D.
    localparam int unsigned CF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned CF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned CF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned CF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
    } t_in;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] det_value;
        logic               singular;
    } t_out;

    // Classified item handed from the front end to the divider back end.
    typedef struct packed {
        logic [N_ELEM-1:0][COF_W-1:0] c_mag;
        logic [N_ELEM-1:0]            neg;
        logic [DET_W-1:0]             dmag;
        logic signed [31:0]           det_value;
        logic                         singular;
    } t_cls;

endpackage

// ----- hw/rtl/matrix3_inverse.sv -----
// 3x3 matrix inverse by adjugate, fixed point, one matrix per cycle when nothing stalls.
// Input queue side: drive i_item and raise i_push; the item is taken at a
// clock edge where i_push is high and o_full is low.
// Result queue side: while o_empty is low, o_item holds the oldest result
// (inverse, rounded determinant, singular flag); raise i_pop to take it.
// Throughput: one item per cycle when nothing stalls, set by the nine
// division lanes that produce one quotient bit per stage.
// Path from the accepting edge to o_empty going low: 5 front stages (the
// first loaded on the accepting edge), the classified-item queue, 35 divider
// stages, the result register and the output queue.
// A stalled receiver fills the output queue, then the divider holds, then
// the middle queue fills and finally o_full rises; nothing is dropped.
// A singular matrix gives all-zero outputs with singular set.
// Reset (synchronous, active low) empties both queues and all stages;
// o_empty is high and o_full low right after it.
module matrix3_inverse import mi3_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    output logic o_full,
    input  logic i_pop,
    output t_out o_item,
    output logic o_empty
);
    logic                   w_ready;
    logic                   w_fv;
    t_cls                   w_fcls;
    logic                   w_mid_full;
    logic                   w_mid_empty;
    logic [$bits(t_cls)-1:0] w_mid_data;
    t_cls                   w_bcls;
    logic                   w_bpop;
    logic                   w_bv;
    t_out                   w_bitem;
    logic                   w_out_full;
    logic [$bits(t_out)-1:0] w_out_data;

    assign o_full = !w_ready;
    assign w_bcls = t_cls'(w_mid_data);
    assign o_item = t_out'(w_out_data);

    mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_push),
        .i_item  (i_item),
        .o_ready (w_ready),
        .o_valid (w_fv),
        .o_cls   (w_fcls),
        .i_full  (w_mid_full)
    );

    mi3_fifo #(.WIDTH($bits(t_cls)), .DEPTH(4)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fv),
        .i_data  (w_fcls),
        .o_full  (w_mid_full),
        .i_pop   (w_bpop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty)
    );

    mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_mid_empty),
        .i_cls   (w_bcls),
        .o_pop   (w_bpop),
        .o_valid (w_bv),
        .o_item  (w_bitem),
        .i_full  (w_out_full)
    );

    mi3_fifo #(.WIDTH($bits(t_out)), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bv),
        .i_data  (w_bitem),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty)
    );
endmodule

// ----- hw/rtl/mi3_fifo.sv -----
// Small register queue with full/empty flags.
module mi3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ----- hw/rtl/mi3_front.sv -----
// Front end: cofactors, exact determinant and classification of each matrix.
module mi3_front import mi3_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_ready,
    output logic o_valid,
    output t_cls o_cls,
    input  logic i_full
);
    logic               w_en;
    logic signed [31:0] w_a [N_ELEM];
    logic [4:0]         r_v;

    logic signed [COF_W-1:0] r_m1 [N_ELEM];
    logic signed [COF_W-1:0] r_m2 [N_ELEM];
    logic signed [31:0]      r_row1 [3];
    logic signed [COF_W-1:0] r_cof2 [N_ELEM];
    logic signed [31:0]      r_row2 [3];
    logic signed [63:0]      r_ph [3];
    logic signed [64:0]      r_pl [3];
    logic signed [COF_W-1:0] r_cof3 [N_ELEM];
    logic signed [DET_W-1:0] r_t [3];
    logic signed [COF_W-1:0] r_cof4 [N_ELEM];
    logic signed [DET_W-1:0] r_det;
    logic signed [COF_W-1:0] r_cof5 [N_ELEM];

    assign w_a[0] = i_item.a00;
    assign w_a[1] = i_item.a01;
    assign w_a[2] = i_item.a02;
    assign w_a[3] = i_item.a10;
    assign w_a[4] = i_item.a11;
    assign w_a[5] = i_item.a12;
    assign w_a[6] = i_item.a20;
    assign w_a[7] = i_item.a21;
    assign w_a[8] = i_item.a22;

    // Advance the whole front while its last stage is empty or the queue has room.
    assign w_en    = !r_v[4] || !i_full;
    assign o_ready = w_en;
    assign o_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_m1[k]   <= w_a[CF_A[k]] * w_a[CF_B[k]];
                r_m2[k]   <= w_a[CF_C[k]] * w_a[CF_D[k]];
                r_cof2[k] <= r_m1[k] - r_m2[k];
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_row1[j] <= w_a[j];
                r_row2[j] <= r_row1[j];
                // split the 32x64 product into two 32x32 halves
                r_ph[j]   <= r_row2[j] * $signed(r_cof2[3*j][63:32]);
                r_pl[j]   <= r_row2[j] * $signed({1'b0, r_cof2[3*j][31:0]});
                r_t[j]    <= (DET_W'(r_ph[j]) <<< 32) + DET_W'(r_pl[j]);
            end
            r_det <= r_t[0] + r_t[1] + r_t[2];
        end
    end

    // Classify: sign, magnitude, rounded determinant, singular flag.
    always_comb begin
        logic               det_neg;
        logic               det_zero;
        logic signed [DET_W:0] rnd;
        logic signed [DET_W:0] shr;
        logic [DET_W-31:0]  top;
        logic signed [31:0] dv;

        det_neg  = r_det[DET_W-1];
        det_zero = (r_det == '0);
        rnd = (DET_W+1)'(r_det) + ((DET_W+1)'(1) <<< (2*FRAC_BITS - 1));
        shr = rnd >>> (2*FRAC_BITS);
        top = shr[DET_W:31];
        if ((&top) || !(|top)) begin
            dv = shr[31:0];
        end else if (shr[DET_W]) begin
            dv = 32'sh8000_0000;
        end else begin
            dv = 32'sh7FFF_FFFF;
        end

        o_cls.dmag      = det_neg ? DET_W'(-r_det) : DET_W'(r_det);
        o_cls.det_value = det_zero ? 32'sd0 : dv;
        o_cls.singular  = det_zero;
        for (int k = 0; k < N_ELEM; k++) begin
            o_cls.c_mag[k] = r_cof5[k][COF_W-1] ? COF_W'(-r_cof5[k]) : COF_W'(r_cof5[k]);
            o_cls.neg[k]   = r_cof5[k][COF_W-1] ^ det_neg;
        end
    end
endmodule

// ----- hw/rtl/mi3_back.sv -----
// Back end: nine restoring-division lanes, rounding and saturation.
module mi3_back import mi3_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cls i_cls,
    output logic o_pop,
    output logic o_valid,
    output t_out o_item,
    input  logic i_full
);
    localparam int NW    = COF_W + 2*FRAC_BITS;
    localparam int NSTEP = QI_BITS + 1;   // integer bits plus one rounding bit

    logic w_en;

    logic [NSTEP:0]          r_v;
    logic [DET_W-1:0]        r_d    [NSTEP+1];
    logic [N_ELEM-1:0]       r_neg  [NSTEP+1];
    logic                    r_sing [NSTEP+1];
    logic signed [31:0]      r_detv [NSTEP+1];
    logic [N_ELEM-1:0]       r_sat  [NSTEP+1];
    logic [DET_W-1:0]        r_p    [NSTEP+1][N_ELEM];
    logic [QI_BITS-1:0]      r_low  [NSTEP+1][N_ELEM];
    logic [NSTEP-1:0]        r_q    [NSTEP+1][N_ELEM];
    logic [DET_W-1:0]        n_p    [NSTEP+1][N_ELEM];
    logic [QI_BITS-1:0]      n_low  [NSTEP+1][N_ELEM];
    logic [NSTEP-1:0]        n_q    [NSTEP+1][N_ELEM];
    logic [N_ELEM-1:0]       n_sat;
    logic signed [31:0]      w_res  [N_ELEM];
    logic                    r_ov;
    t_out                    r_item;

    assign w_en    = !r_ov || !i_full;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_ov;
    assign o_item  = r_item;

    always_comb begin
        logic [NW-1:0]    num;
        logic [DET_W:0]   p2;
        logic             ge;
        logic [NSTEP-1:0] qr;

        // Load: partial remainder is the numerator above the quotient bits.
        for (int k = 0; k < N_ELEM; k++) begin
            num         = NW'(i_cls.c_mag[k]) << (2*FRAC_BITS);
            n_p[0][k]   = DET_W'(num >> QI_BITS);
            n_low[0][k] = num[QI_BITS-1:0];
            n_q[0][k]   = '0;
            n_sat[k]    = (DET_W'(num >> QI_BITS) >= i_cls.dmag);
        end
        // One quotient bit per stage.
        for (int s = 1; s <= NSTEP; s++) begin
            for (int k = 0; k < N_ELEM; k++) begin
                p2 = {r_p[s-1][k], r_low[s-1][k][QI_BITS-1]};
                ge = (p2 >= {1'b0, r_d[s-1]});
                n_p[s][k]   = ge ? DET_W'(p2 - {1'b0, r_d[s-1]}) : p2[DET_W-1:0];
                n_low[s][k] = r_low[s-1][k] << 1;
                n_q[s][k]   = {r_q[s-1][k][NSTEP-2:0], ge};
            end
        end
        // Round half away from zero on the magnitude, then saturate.
        for (int k = 0; k < N_ELEM; k++) begin
            qr = (r_q[NSTEP][k] >> 1) + NSTEP'(r_q[NSTEP][k][0]);
            if (r_sing[NSTEP]) begin
                w_res[k] = 32'sd0;
            end else if (r_neg[NSTEP][k]) begin
                if (r_sat[NSTEP][k] || qr > NSTEP'(34'h0_8000_0000)) begin
                    w_res[k] = 32'sh8000_0000;
                end else begin
                    w_res[k] = -$signed(qr[31:0]);
                end
            end else begin
                if (r_sat[NSTEP][k] || qr > NSTEP'(34'h0_7FFF_FFFF)) begin
                    w_res[k] = 32'sh7FFF_FFFF;
                end else begin
                    w_res[k] = $signed(qr[31:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[NSTEP-1:0], i_valid};
            r_ov <= r_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0]    <= i_cls.dmag;
            r_neg[0]  <= i_cls.neg;
            r_sing[0] <= i_cls.singular;
            r_detv[0] <= i_cls.det_value;
            r_sat[0]  <= n_sat;
            for (int s = 1; s <= NSTEP; s++) begin
                r_d[s]    <= r_d[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_sing[s] <= r_sing[s-1];
                r_detv[s] <= r_detv[s-1];
                r_sat[s]  <= r_sat[s-1];
            end
            for (int s = 0; s <= NSTEP; s++) begin
                for (int k = 0; k < N_ELEM; k++) begin
                    r_p[s][k]   <= n_p[s][k];
                    r_low[s][k] <= n_low[s][k];
                    r_q[s][k]   <= n_q[s][k];
                end
            end
            r_item.r00       <= w_res[0];
            r_item.r01       <= w_res[1];
            r_item.r02       <= w_res[2];
            r_item.r10       <= w_res[3];
            r_item.r11       <= w_res[4];
            r_item.r12       <= w_res[5];
            r_item.r20       <= w_res[6];
            r_item.r21       <= w_res[7];
            r_item.r22       <= w_res[8];
            r_item.det_value <= r_detv[NSTEP];
            r_item.singular  <= r_sing[NSTEP];
        end
    end
endmodule

// ----- hw/rtl/mi3_checker.sv -----
// Port-level checks for matrix3_inverse and their bind.
`include "matrix3_inverse_assert.svh"

module mi3_checker import mi3_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_full,
    input logic i_pop,
    input t_out o_item,
    input logic o_empty
);
    // singular result carries an all-zero inverse and determinant
    `MI3_ASSERT(a_sing_zero, !o_empty && o_item.singular, o_item[$bits(t_out)-1:1] == '0)

    // reset leaves both queues idle
    `MI3_ASSERT_NEXT(a_rst_idle, !i_rst_n, o_empty && !o_full)

    // an item not taken stays put
    `MI3_ASSERT_NEXT(a_hold, i_rst_n && !o_empty && !i_pop, !o_empty && $stable(o_item))
endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (.*);

// ----- sim/matrix3_inverse_test.sv -----
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
module matrix3_inverse_test;
    import mi3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_WAIT = 60;
    localparam int LONG_HOLD  = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_push;
    t_in  i_item;
    logic o_full;
    logic i_pop;
    t_out o_item;
    logic o_empty;

    t_out inverse_q[$];
    int   n_errors;
    int   idle_cycles;
    bit   hold_req;
    int   burst_left;

    matrix3_inverse #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_item (i_item),
        .o_full (o_full),
        .i_pop  (i_pop),
        .o_item (o_item),
        .o_empty(o_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to the 32-bit range.
    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -128'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_out invert_matrix(t_in m);
        logic signed [127:0] a [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic signed [127:0] rnd;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        q;
        logic [127:0]        rem;
        logic [31:0]         el [9];
        t_out                r;
        bit                  neg;
        a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
        a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
        a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[1] = a[2] * a[7] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[2] * a[4];
        cof[3] = a[5] * a[6] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[2] * a[6];
        cof[5] = a[2] * a[3] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[4] * a[6];
        cof[7] = a[1] * a[6] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        rnd = (det + (128'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
        r.det_value = clamp32(rnd);
        dmag = (det < 0) ? -det : det;
        for (int k = 0; k < 9; k++) begin
            num = ((cof[k] < 0) ? -cof[k] : cof[k]) << (2 * FRAC);
            q   = num / dmag;
            rem = num % dmag;
            if ((rem << 1) >= dmag) q = q + 1;
            neg = (cof[k] < 0) != (det < 0);
            if (q == 0) el[k] = '0;
            else if (neg) el[k] = (q > 128'h80000000) ? 32'h80000000 : -q[31:0];
            else el[k] = (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end
        r.r00 = el[0]; r.r01 = el[1]; r.r02 = el[2];
        r.r10 = el[3]; r.r11 = el[4]; r.r12 = el[5];
        r.r20 = el[6]; r.r21 = el[7]; r.r22 = el[8];
        return r;
    endfunction

    function automatic t_in make_matrix(logic signed [31:0] e00, logic signed [31:0] e01,
                                        logic signed [31:0] e02, logic signed [31:0] e10,
                                        logic signed [31:0] e11, logic signed [31:0] e12,
                                        logic signed [31:0] e20, logic signed [31:0] e21,
                                        logic signed [31:0] e22);
        t_in m;
        m.a00 = e00; m.a01 = e01; m.a02 = e02;
        m.a10 = e10; m.a11 = e11; m.a12 = e12;
        m.a20 = e20; m.a21 = e21; m.a22 = e22;
        return m;
    endfunction

    function automatic logic signed [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return ($signed($urandom_range(0, 16)) - 8) <<< FRAC;
            3: return $signed($urandom_range(0, 64)) - 32;
            default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    function automatic t_in rand_matrix();
        t_in m;
        int  kind;
        int  pick;
        kind = $urandom_range(0, 9);
        pick = (kind < 2) ? 0 : (kind < 6) ? 1 : (kind < 8) ? 2 : (kind < 9) ? 3 : 4;
        m = make_matrix(rand_elem(pick), rand_elem(pick), rand_elem(pick),
                        rand_elem(pick), rand_elem(pick), rand_elem(pick),
                        rand_elem(pick), rand_elem(pick), rand_elem(pick));
        // make some matrices singular by repeating or zeroing a row
        case ($urandom_range(0, 11))
            0: begin m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02; end
            1: begin m.a10 = 0; m.a11 = 0; m.a12 = 0; end
            default: ;
        endcase
        return m;
    endfunction

    // Offer one item and hold it until taken; push stays high afterward.
    task automatic send_matrix(t_in m);
        i_push <= 1'b1;
        i_item <= m;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    // Insert random gaps between bursts.
    task automatic send_paced(t_in m);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                i_push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        send_matrix(m);
    endtask

    task automatic wait_results();
        i_push <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_in dir [$];
        dir.push_back(make_matrix(32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000));
        dir.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        dir.push_back(make_matrix(32'sh80000000, 0, 0, 0, 32'sh80000000, 0,
                                  0, 0, 32'sh80000000));
        dir.push_back(make_matrix(32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF, 0,
                                  0, 0, 32'sh7FFFFFFF));
        dir.push_back(make_matrix(32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF,
                                  32'sh80000000, 0, 0, 0, 32'sh80000000));
        dir.push_back(make_matrix(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                                  32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
        // tiny determinant: rounds to zero but is not singular
        dir.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        dir.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        // determinant exactly half an LSB, both signs
        dir.push_back(make_matrix(2, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000));
        dir.push_back(make_matrix(-2, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000));
        // diagonal matrix: inverse elements 1/2, 1/3 and 1/7
        dir.push_back(make_matrix(32'sh20000, 0, 0, 0, 32'sh30000, 0, 0, 0, 32'sh70000));
        dir.push_back(make_matrix(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000,
                                  32'sh50000, 32'sh60000, 32'sh70000, 32'sh80000,
                                  32'sh90000));
        dir.push_back(make_matrix(32'sh20000, -32'sh10000, 0, -32'sh10000, 32'sh20000,
                                  -32'sh10000, 0, -32'sh10000, 32'sh20000));
        dir.push_back(make_matrix(0, 32'sh10000, 0, 0, 0, 32'sh10000,
                                  32'sh10000, 0, 0));
        dir.push_back(make_matrix(-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0,
                                  -32'sh10000));
        dir.push_back(make_matrix(32'sh0100, 32'sh0001, 0, 0, 32'sh0100, 0,
                                  0, 0, 32'sh0100));
        dir.push_back(make_matrix(32'shFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                                  32'h0F0F0F0F, 32'hF0F0F0F0, 32'h33333333,
                                  32'hCCCCCCCC, 32'h00FF00FF, 32'hFF00FF00));
        foreach (dir[k]) send_matrix(dir[k]);
        wait_results();
    endtask

    task automatic test_random(int count);
        burst_left = 0;
        repeat (count) send_paced(rand_matrix());
        i_push <= 1'b0;
    endtask

    // Stop popping for a long stretch while the input keeps offering items.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (200) send_matrix(rand_matrix());
        hold_req = 1'b0;
        wait_results();
    endtask

    // Receiver: stall pattern drawn at random from four modes.
    initial begin
        int mode;
        int hold_left;
        int cyc;
        bit hold_armed;
        i_pop = 1'b0;
        mode = 0;
        hold_left = 0;
        cyc = 0;
        hold_armed = 1'b0;
        forever begin
            @(posedge i_clk);
            // one long hold per request
            if (hold_req && !hold_armed) begin
                hold_left = LONG_HOLD;
                hold_armed = 1'b1;
            end
            if (!hold_req) hold_armed = 1'b0;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                case (mode)
                    0: i_pop <= 1'b1;
                    1: i_pop <= $urandom_range(0, 1);
                    2: i_pop <= ($urandom_range(0, 3) == 0);
                    default: i_pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic check_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Predict on accept, compare on pop, and watch for stalls.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_push && !o_full) begin
                inverse_q.push_back(invert_matrix(i_item));
            end
            if (i_pop && !o_empty) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_item);
                    n_errors++;
                end else begin
                    exp_r = inverse_q.pop_front();
                    check_field("r00", exp_r.r00, o_item.r00);
                    check_field("r01", exp_r.r01, o_item.r01);
                    check_field("r02", exp_r.r02, o_item.r02);
                    check_field("r10", exp_r.r10, o_item.r10);
                    check_field("r11", exp_r.r11, o_item.r11);
                    check_field("r12", exp_r.r12, o_item.r12);
                    check_field("r20", exp_r.r20, o_item.r20);
                    check_field("r21", exp_r.r21, o_item.r21);
                    check_field("r22", exp_r.r22, o_item.r22);
                    check_field("det_value", exp_r.det_value, o_item.det_value);
                    check_field("singular", exp_r.singular, o_item.singular);
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("[matrix3_inverse] ERROR");
                $finish;
            end
        end
    end

    initial begin
        n_errors = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_item = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(800);
        test_backpressure();
        test_random(800);
        wait_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0 && inverse_q.size() == 0) begin
            $display("[matrix3_inverse] OK");
        end else begin
            $display("[matrix3_inverse] ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_fifo.sv
hw/rtl/mi3_front.sv
hw/rtl/mi3_back.sv
hw/rtl/matrix3_inverse.sv
hw/rtl/mi3_checker.sv
sim/matrix3_inverse_test.sv
